// ===== rtl/sorted_priority_table_insert_defines.svh =====
// Assertion macros for the sorted priority table insert block.
// No dependencies; included by the RTL files that carry assertions.
`ifndef SORTED_PRIORITY_TABLE_INSERT_DEFINES_SVH
`define SORTED_PRIORITY_TABLE_INSERT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPTI_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPTI_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/spti_pkg.sv =====
// Shared types and constants for the sorted priority table insert block.
// No dependencies; imported by spti_cell and sorted_priority_table_insert.
package spti_pkg;

    localparam int PRIO_W   = 8;
    localparam int PAY_IN_W = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int CNT_W    = 5;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 16;
    localparam int PAY_EXT_W = 64;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO = 2'd2;

    // Insert command broadcast to every cell.
    typedef struct packed {
        logic              en;
        logic [PRIO_W-1:0] prio;
    } t_cmd;

    // Link from one cell to its right neighbor.
    typedef struct packed {
        logic              vld;
        logic              gt;   // slot is empty or holds a larger priority
        logic [PRIO_W-1:0] prio;
    } t_link;

endpackage

// ===== rtl/spti_cell.sv =====
// One slot of the sorted table: priority, payload and a valid bit.
// Depends on spti_pkg.
module spti_cell #(
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  spti_pkg::t_cmd           i_cmd,
    input  logic [PAYLOAD_WIDTH-1:0] i_new_pay,
    input  spti_pkg::t_link          i_left,
    input  logic [PAYLOAD_WIDTH-1:0] i_left_pay,
    output spti_pkg::t_link          o_link,
    output logic [PAYLOAD_WIDTH-1:0] o_pay,
    output logic                     o_hit
);
    import spti_pkg::*;

    logic               r_vld;
    logic [PRIO_W-1:0]  r_prio;
    logic [PAYLOAD_WIDTH-1:0] r_pay;
    logic               gt;
    logic               take_left;

    assign gt        = !r_vld || (r_prio > i_cmd.prio);
    assign take_left = i_left.gt;
    // First slot that is empty or whose content is larger receives the new entry.
    assign o_hit     = gt && !i_left.gt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_prio <= '0;
        end else if (i_cmd.en) begin
            if (take_left) begin
                r_vld  <= i_left.vld;
                r_prio <= i_left.prio;
            end else if (o_hit) begin
                r_vld  <= 1'b1;
                r_prio <= i_cmd.prio;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.en) begin
            if (take_left) begin
                r_pay <= i_left_pay;
            end else if (o_hit) begin
                r_pay <= i_new_pay;
            end
        end
    end

    assign o_link.vld  = r_vld;
    assign o_link.gt   = gt;
    assign o_link.prio = r_prio;
    assign o_pay       = r_pay;

endmodule

// ===== rtl/sorted_priority_table_insert.sv =====
// Top level of the sorted priority table insert block: stream ports,
// result register and the row of table cells. Depends on spti_pkg,
// spti_cell and sorted_priority_table_insert_defines.svh.
//
//  Channel   Direction  Transfer condition      Content
//  s_axis    in         tvalid & tready         priority_req, payload
//  m_axis    out        tvalid & tready         status, position, count
//
// Each accepted transfer is resolved by one compare across the cell row: every cell compares its
// stored priority against the new one and either keeps, takes the new entry
// or takes its left neighbor's entry, so one item per cycle is sustained while
// the receiver does not hold the output register with backpressure.
// The result sits in an output register; a new transfer is taken whenever
// that register is empty or being drained in the same cycle.
// Reset (synchronous, active low) empties every cell and clears the count.
module sorted_priority_table_insert #(
    parameter int MAX_ENTRIES   = 16,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // [7:0] priority_req, [39:8] payload
    input  logic [spti_pkg::IN_W-1:0]  i_s_axis_tdata,
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    // [1:0] status, [5:2] position, [10:6] count, [15:11] zero
    output logic [spti_pkg::OUT_W-1:0] o_m_axis_tdata
);
    import spti_pkg::*;
    `include "sorted_priority_table_insert_defines.svh"

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_IW = $clog2(MAX_ENTRIES + 1);

    // Input unpack.
    logic [PRIO_W-1:0]        in_prio;
    logic [PAY_IN_W-1:0]      in_pay;
    logic [PAY_EXT_W-1:0]     pay_ext;
    logic [PAYLOAD_WIDTH-1:0] new_pay;

    assign in_prio = i_s_axis_tdata[PRIO_W-1:0];
    assign in_pay  = i_s_axis_tdata[PRIO_W +: PAY_IN_W];
    // Keep the low PAYLOAD_WIDTH bits, zero above the input field.
    assign pay_ext = PAY_EXT_W'(in_pay);
    assign new_pay = pay_ext[PAYLOAD_WIDTH-1:0];

    // Handshake and output register.
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;
    logic              s_fire;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Cell row: link[i] feeds cell i, cell i drives link[i+1].
    t_link                    link     [MAX_ENTRIES+1];
    logic [PAYLOAD_WIDTH-1:0] link_pay [MAX_ENTRIES+1];
    logic [MAX_ENTRIES-1:0]   hit;
    t_cmd                     cmd;
    logic                     full;

    logic [CNT_IW-1:0]        r_count;
    logic [STATUS_W-1:0]      status;
    logic [IDX_W-1:0]         pos;

    assign full = link[MAX_ENTRIES].vld;

    // Zero priority is checked before the full condition.
    always_comb begin
        if (in_prio == '0) begin
            status = ST_ZERO;
        end else if (full) begin
            status = ST_FULL;
        end else begin
            status = ST_OK;
        end
    end

    assign cmd.en   = s_fire && (status == ST_OK);
    assign cmd.prio = in_prio;

    assign link[0].vld  = 1'b0;
    assign link[0].gt   = 1'b0;
    assign link[0].prio = '0;
    assign link_pay[0]  = '0;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        spti_cell #(
            .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (cmd),
            .i_new_pay  (new_pay),
            .i_left     (link[g]),
            .i_left_pay (link_pay[g]),
            .o_link     (link[g+1]),
            .o_pay      (link_pay[g+1]),
            .o_hit      (hit[g])
        );
    end

    // Encode the one-hot insert slot; the first cell that is empty or holds
    // a larger priority is the only hit.
    always_comb begin
        pos = '0;
        for (int k = 0; k < MAX_ENTRIES; k++) begin
            if (hit[k]) begin
                pos = pos | IDX_W'(k);
            end
        end
    end

    // Result fields, masked to their port widths.
    logic [CNT_IW-1:0] n_count;
    logic [31:0]       cnt_wide;
    logic [31:0]       pos_wide;
    logic [POS_W-1:0]  res_pos;
    logic [CNT_W-1:0]  res_cnt;

    assign n_count  = (status == ST_OK) ? r_count + CNT_IW'(1) : r_count;
    assign cnt_wide = 32'(n_count);
    assign pos_wide = (status == ST_OK) ? 32'(pos) : 32'd0;
    assign res_cnt  = cnt_wide[CNT_W-1:0];
    assign res_pos  = pos_wide[POS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                // Drop the result once the far side has taken it.
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_out_data <= {(OUT_W - STATUS_W - POS_W - CNT_W)'(0), res_cnt, res_pos, status};
        end
    end

    `SPTI_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= CNT_IW'(MAX_ENTRIES), "entry count above table depth")
    `SPTI_ASSERT_NOW(a_full_match, i_clk, i_rst_n, 1'b1,
        full == (r_count == CNT_IW'(MAX_ENTRIES)), "last cell valid disagrees with count")
    `SPTI_ASSERT_NOW(a_hit_onehot, i_clk, i_rst_n, cmd.en,
        $onehot(hit), "insert without exactly one target slot")
    `SPTI_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, cmd.en,
        r_count == $past(r_count) + CNT_IW'(1), "count not advanced on insert")

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for sorted_priority_table_insert: fills the table with mixed priorities,
// then keeps inserting against a full table. Depends on spti_pkg and the block's RTL only;
// a scoreboard class tracks the sorted table and checks every result transfer.
`timescale 1ns / 1ps

module tb;
    import spti_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int RANDOM_ITEMS = 1600;

    // Result word as it sits in the low bits of o_m_axis_tdata, status lowest.
    typedef struct packed {
        logic [CNT_W-1:0]    count;
        logic [POS_W-1:0]    position;
        logic [STATUS_W-1:0] status;
    } t_result;

    // Mirror of the priority table; predicts status, slot and count per insert.
    class prio_table_scoreboard;
        logic [PRIO_W-1:0]   prio_slots[TABLE_DEPTH];
        logic [PAY_IN_W-1:0] payload_slots[TABLE_DEPTH];
        int unsigned         entries;
        t_result             pending[$];
        int unsigned         errors;

        function new();
            entries = 0;
            errors  = 0;
            foreach (prio_slots[i]) prio_slots[i] = '0;
        endfunction

        function void note_insert(logic [PRIO_W-1:0] prio, logic [PAY_IN_W-1:0] payload);
            t_result     want;
            int unsigned slot;
            want.status   = ST_OK;
            want.position = '0;
            if (prio == '0) begin
                want.status = ST_ZERO;
            end else if (entries >= TABLE_DEPTH) begin
                want.status = ST_FULL;
            end else begin
                // Land before the first strictly larger priority; ties keep arrival order.
                slot = entries;
                for (int i = entries - 1; i >= 0; i--) begin
                    if (prio_slots[i] > prio) slot = i;
                end
                for (int i = entries; i > slot; i--) begin
                    prio_slots[i]    = prio_slots[i-1];
                    payload_slots[i] = payload_slots[i-1];
                end
                prio_slots[slot]    = prio;
                payload_slots[slot] = payload;
                entries++;
                want.position = slot[POS_W-1:0];
            end
            want.count = entries[CNT_W-1:0];
            pending.push_back(want);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                $error("result with nothing pending: status %0d position %0d count %0d",
                       got.status, got.position, got.count);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.position !== want.position) begin
                $error("position: expected %0d, got %0d", want.position, got.position);
                errors++;
            end
            if (got.count !== want.count) begin
                $error("count: expected %0d, got %0d", want.count, got.count);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    // [7:0] priority_req, [39:8] payload
    logic [IN_W-1:0]     i_s_axis_tdata = '0;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    // [1:0] status, [5:2] position, [10:6] count, [15:11] zero
    logic [OUT_W-1:0]    o_m_axis_tdata;

    prio_table_scoreboard sb = new();
    int unsigned          rx_cycle = 0;

    sorted_priority_table_insert #(
        .MAX_ENTRIES   (TABLE_DEPTH),
        .PAYLOAD_WIDTH (PAY_IN_W)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver backpressure: rotate through four stall patterns, one of which never
    // stalls, so gaps land on every phase of the output register.
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle / 256) % 4)
            0: begin
                i_m_axis_tready <= 1'b1;
            end
            1: begin
                i_m_axis_tready <= (rx_cycle % 3) != 0;
            end
            2: begin
                i_m_axis_tready <= $urandom_range(0, 3) != 0;
            end
            default: begin
                i_m_axis_tready <= (rx_cycle % 8) < 5;
            end
        endcase
    end

    // Sample at the falling edge: inputs move only at rising edges, so a transfer
    // seen here is the one that completes at the next rising edge.
    always @(negedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            sb.check_result(t_result'(o_m_axis_tdata[CNT_W+POS_W+STATUS_W-1:0]));
        end
    end

    // Present one insert and hold it until the transfer; called and returns at a rising edge.
    task automatic send_insert(input logic [PRIO_W-1:0] prio, input logic [PAY_IN_W-1:0] payload);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {payload, prio};
        do @(negedge i_clk); while (!o_s_axis_tready);
        @(posedge i_clk);
        sb.note_insert(prio, payload);
    endtask

    // Drop valid for a number of cycles; zero keeps the stream back to back.
    task automatic sender_gap(input int unsigned cycles);
        if (cycles > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    function automatic logic [PRIO_W-1:0] pick_priority();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) return '0;
        if (roll < 15) return 8'd1;
        if (roll < 20) return 8'd255;
        // Narrow range to force ties while the table is still filling.
        if (roll < 40) return 8'($urandom_range(1, 4));
        return 8'($urandom_range(1, 255));
    endfunction

    initial begin
        int unsigned burst;
        int unsigned sent;
        int unsigned drain_wait;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero priority on an empty table, the priority extremes, equal
        // priorities in arrival order, a new most-urgent entry at slot zero, appends.
        send_insert(8'd0,   32'hFFFF_FFFF);
        send_insert(8'd255, 32'h0000_0000);
        send_insert(8'd1,   32'hFFFF_FFFF);
        send_insert(8'd128, 32'h1234_5678);
        sender_gap(3);
        send_insert(8'd128, 32'h9ABC_DEF0);
        send_insert(8'd1,   32'h0000_0000);
        send_insert(8'd255, 32'hA5A5_A5A5);
        send_insert(8'd0,   32'h0000_0000);
        send_insert(8'd200, 32'h5A5A_5A5A);
        sender_gap(1);

        // Random: the table fills within the first few dozen items; after that every
        // insert must be turned away as full, unless its priority is zero.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
                send_insert(pick_priority(), $urandom);
                sent++;
            end
            if ($urandom_range(0, 3) != 0) sender_gap($urandom_range(0, 6));
        end
        i_s_axis_tvalid <= 1'b0;

        // Drain: wait for every expected result, then keep watching for stray output.
        drain_wait = 0;
        while (sb.pending.size() != 0 && drain_wait < 2000) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (8) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/spti_pkg.sv
rtl/spti_cell.sv
rtl/sorted_priority_table_insert.sv
tb/tb.sv
